>>> design/psl_pkg.sv
// Shared types and codes for the positional shift list.
package psl_pkg;

    // Width of the position and count fields carried to every cell
    localparam int unsigned POS_W = 8;

    // Request codes on the op field
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BAD_POS = 2'd3;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;    // insert takes effect this cycle
        logic             rem;    // remove takes effect this cycle
        logic [POS_W-1:0] slot;   // 0-based target slot
        logic [POS_W-1:0] count;  // entry count before the request
    } t_cell_cmd;

endpackage

>>> design/psl_cell.sv
// One storage cell of the shift chain: holds, loads or takes a neighbor's entry.
module psl_cell #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned INDEX      = 0
) (
    input  logic                  i_clk,
    input  psl_pkg::t_cell_cmd    i_cmd,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_entry
);

    localparam logic [psl_pkg::POS_W:0] MY_IDX = (psl_pkg::POS_W + 1)'(INDEX);

    logic [DATA_WIDTH-1:0]   r_entry;
    logic [DATA_WIDTH-1:0]   n_entry;
    logic [psl_pkg::POS_W:0] w_slot;
    logic [psl_pkg::POS_W:0] w_count;

    assign w_slot  = {1'b0, i_cmd.slot};
    assign w_count = {1'b0, i_cmd.count};

    // Pick the next entry from the broadcast command and this cell's place
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (MY_IDX == w_slot) begin
                n_entry = i_data;
            end else if (MY_IDX > w_slot && MY_IDX <= w_count) begin
                n_entry = i_left;
            end
        end else if (i_cmd.rem) begin
            if (MY_IDX >= w_slot && MY_IDX + 1'b1 < w_count) begin
                n_entry = i_right;
            end
        end
    end

    // Hold the entry
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> design/positional_shift_list.sv
// Top level of the positional shift list: request decode, cell chain and result register.
//
// The list is a chain of DEPTH cells; on each accepted request every cell loads the new
// entry, takes its left or right neighbor's entry, or holds, so an insert or remove at any
// position is one chain update. Requests carry a 1-based position: inserts clamp to the
// head or tail and are refused when full; removes and reads are refused when the list is
// empty or the position is outside 1..count. Each request gives one result in the cycle
// after its transfer; a new request is taken every cycle while the result side keeps up;
// the single output register is what limits the rate. Entries have no reset: after reset
// the list is empty and only written entries are ever read.
module positional_shift_list #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_entry_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_read_data,
    output logic [6:0]  o_entry_count,
    output logic        o_list_empty,
    output logic        o_list_full
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = psl_pkg::POS_W + 1;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic [1:0]            n_status;
    logic [31:0]           r_read_data;
    logic [31:0]           n_read_data;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  w_xfer;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_cnt;
    logic [CMP_W-1:0]      w_slot;
    logic [DATA_WIDTH-1:0] w_data;
    logic [DATA_WIDTH-1:0] w_entry [DEPTH];
    psl_pkg::t_cell_cmd    w_cmd;

    // Take a request whenever the result register is free or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_xfer     = i_in_valid && o_in_ready;

    assign w_pos  = {1'b0, i_position};
    assign w_cnt  = CMP_W'(r_count);
    assign w_data = DATA_WIDTH'(i_entry_data);

    // Decode the request into a status, a target slot and the cell command
    always_comb begin
        n_status    = psl_pkg::ST_DONE;
        n_read_data = '0;
        n_count     = r_count;
        w_slot      = w_pos - 1'b1;
        w_cmd.ins   = 1'b0;
        w_cmd.rem   = 1'b0;
        unique case (i_op)
            psl_pkg::OP_INSERT: begin
                if (w_cnt >= DEPTH_C) begin
                    n_status = psl_pkg::ST_FULL;
                end else begin
                    priority if (w_pos <= CMP_W'(1)) begin
                        w_slot = '0;
                    end else if (w_pos > w_cnt + 1'b1) begin
                        w_slot = w_cnt;
                    end else begin
                        w_slot = w_pos - 1'b1;
                    end
                    w_cmd.ins = w_xfer;
                    n_count   = r_count + 1'b1;
                end
            end
            psl_pkg::OP_REMOVE, psl_pkg::OP_READ: begin
                priority if (w_cnt == '0) begin
                    n_status = psl_pkg::ST_EMPTY;
                end else if (w_pos == '0 || w_pos > w_cnt) begin
                    n_status = psl_pkg::ST_BAD_POS;
                end else if (i_op == psl_pkg::OP_REMOVE) begin
                    w_cmd.rem = w_xfer;
                    n_count   = r_count - 1'b1;
                end else begin
                    n_read_data = 32'(w_entry[w_slot[IDX_W-1:0]]);
                end
            end
            default: begin
                n_status = psl_pkg::ST_DONE;
            end
        endcase
        w_cmd.slot  = w_slot[psl_pkg::POS_W-1:0];
        w_cmd.count = psl_pkg::POS_W'(r_count);
    end

    // Build the chain of cells, each wired to its neighbors; the ends see zero or their own entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        psl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_data  (w_data),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g])
        );
    end

    // Advance the count and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_xfer) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result payload on each request transfer
    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_status    <= n_status;
            r_read_data <= n_read_data;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_data   = r_read_data;
    assign o_entry_count = 7'(r_count);
    assign o_list_empty  = (r_count == '0);
    assign o_list_full   = (CMP_W'(r_count) == DEPTH_C);

endmodule

>>> tb/positional_shift_list_checker.sv
`timescale 1ns / 100ps
// Result checker for the positional shift list: watches both channels, predicts and compares.
module positional_shift_list_checker #(
    parameter int unsigned DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_entry_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_read_data,
    input  logic [6:0]  i_entry_count,
    input  logic        i_list_empty,
    input  logic        i_list_full,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic [6:0]  entry_count;
        logic        list_empty;
        logic        list_full;
    } t_list_result;

    // Shadow copy of the list contents and length
    logic [31:0]  list_entries [DEPTH];
    int unsigned  list_len = 0;
    t_list_result expected_results [$];
    t_list_result oldest;

    initial o_fail_count = 0;
    initial o_pending    = 0;

    // Apply one request to the shadow list and return the result it should give
    function automatic t_list_result apply_request(input logic [1:0] op,
                                                   input logic [7:0] pos,
                                                   input logic [31:0] data);
        t_list_result res;
        int unsigned  slot;
        res.status    = psl_pkg::ST_DONE;
        res.read_data = '0;
        if (op == psl_pkg::OP_INSERT) begin
            if (list_len >= DEPTH) begin
                res.status = psl_pkg::ST_FULL;
            end else begin
                // clamp to the head or the tail
                if (pos <= 1)
                    slot = 0;
                else if (pos > list_len + 1)
                    slot = list_len;
                else
                    slot = pos - 1;
                for (int unsigned i = list_len; i > slot; i--)
                    list_entries[i] = list_entries[i - 1];
                list_entries[slot] = data;
                list_len++;
            end
        end else if (op == psl_pkg::OP_REMOVE || op == psl_pkg::OP_READ) begin
            if (list_len == 0) begin
                res.status = psl_pkg::ST_EMPTY;
            end else if (pos < 1 || pos > list_len) begin
                res.status = psl_pkg::ST_BAD_POS;
            end else if (op == psl_pkg::OP_REMOVE) begin
                for (int unsigned i = pos - 1; i + 1 < list_len; i++)
                    list_entries[i] = list_entries[i + 1];
                list_len--;
            end else begin
                res.read_data = list_entries[pos - 1];
            end
        end
        // unused op code leaves the list alone
        res.entry_count = list_len[6:0];
        res.list_empty  = (list_len == 0);
        res.list_full   = (list_len == DEPTH);
        return res;
    endfunction

    // Compare one field and log a mismatch
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Check result transfers first, then record the request transfer of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual status %h count %h",
                             $time, i_status, i_entry_count);
                    o_fail_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("status", 32'(oldest.status), 32'(i_status));
                    check_field("read_data", oldest.read_data, i_read_data);
                    check_field("entry_count", 32'(oldest.entry_count), 32'(i_entry_count));
                    check_field("list_empty", 32'(oldest.list_empty), 32'(i_list_empty));
                    check_field("list_full", 32'(oldest.list_full), 32'(i_list_full));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_request(i_op, i_position, i_entry_data));
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/positional_shift_list_tb.sv
`timescale 1ns / 100ps
// Top of the positional shift list testbench: clock, reset, request and result-side drive.
module positional_shift_list_tb;

    localparam int unsigned DEPTH         = 64;
    localparam int unsigned DATA_WIDTH    = 32;
    localparam int          ITEMS_PER_SET = 213;

    // Op code with no function; the block must answer it without touching the list
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        req_valid    = 1'b0;
    logic        req_ready;
    logic [1:0]  req_op       = psl_pkg::OP_INSERT;
    logic [7:0]  req_position = '0;
    logic [31:0] req_entry    = '0;
    logic        rsp_valid;
    logic        rsp_ready    = 1'b0;
    logic [1:0]  rsp_status;
    logic [31:0] rsp_read_data;
    logic [6:0]  rsp_entry_count;
    logic        rsp_list_empty;
    logic        rsp_list_full;
    int          fail_count;
    int          pending_count;

    // Idle and stall rates, in percent, set per phase
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // Long receiver hold-off, requested by the stimulus and counted by the receiver
    logic        hold_req    = 1'b0;
    logic        hold_served = 1'b0;
    int          hold_left   = 0;

    // Rough list length, used only to aim positions
    int unsigned occupancy_hint = 0;
    bit          filling        = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    positional_shift_list #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (req_valid),
        .o_in_ready    (req_ready),
        .i_op          (req_op),
        .i_position    (req_position),
        .i_entry_data  (req_entry),
        .o_out_valid   (rsp_valid),
        .i_out_ready   (rsp_ready),
        .o_status      (rsp_status),
        .o_read_data   (rsp_read_data),
        .o_entry_count (rsp_entry_count),
        .o_list_empty  (rsp_list_empty),
        .o_list_full   (rsp_list_full)
    );

    positional_shift_list_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (req_valid),
        .i_in_ready    (req_ready),
        .i_op          (req_op),
        .i_position    (req_position),
        .i_entry_data  (req_entry),
        .i_out_valid   (rsp_valid),
        .i_out_ready   (rsp_ready),
        .i_status      (rsp_status),
        .i_read_data   (rsp_read_data),
        .i_entry_count (rsp_entry_count),
        .i_list_empty  (rsp_list_empty),
        .i_list_full   (rsp_list_full),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // Drive result-side ready: long hold-off when asked, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_served) begin
            hold_served <= 1'b1;
            hold_left   <= 300;
            rsp_ready   <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one request and hold it until its transfer
    task automatic offer_request(input logic [1:0] op, input logic [7:0] pos,
                                 input logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid    <= 1'b1;
        req_op       <= op;
        req_position <= pos;
        req_entry    <= data;
        @(posedge i_clk);
        while (!req_ready)
            @(posedge i_clk);
        // track the length to aim later positions
        if (op == psl_pkg::OP_INSERT && occupancy_hint < DEPTH)
            occupancy_hint++;
        else if (op == psl_pkg::OP_REMOVE && pos >= 1 && pos <= occupancy_hint)
            occupancy_hint--;
    endtask

    // Mostly aimed fill and drain traffic, some noise over the whole field range
    task automatic offer_random();
        logic [1:0] op;
        logic [7:0] pos;
        if ($urandom_range(99) < 10) begin
            op  = 2'($urandom_range(3));
            pos = 8'($urandom_range(255));
        end else if ($urandom_range(99) < (filling ? 75 : 25)) begin
            op = psl_pkg::OP_INSERT;
            case ($urandom_range(7))
                0:       pos = 8'd0;
                1:       pos = 8'hFF;
                default: pos = 8'($urandom_range(occupancy_hint + 1));
            endcase
        end else begin
            op = $urandom_range(1) ? psl_pkg::OP_REMOVE : psl_pkg::OP_READ;
            if (occupancy_hint == 0 || $urandom_range(7) == 0)
                pos = $urandom_range(1) ? 8'd0 : 8'(occupancy_hint + 1);
            else
                pos = 8'($urandom_range(occupancy_hint, 1));
        end
        offer_request(op, pos, $urandom());
        // turn around near the ends, after a few refused requests
        if (occupancy_hint == DEPTH && $urandom_range(3) == 0)
            filling = 1'b0;
        else if (occupancy_hint == 0 && $urandom_range(3) == 0)
            filling = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty refusals, unused op, head/middle/tail inserts and removes
        offer_request(psl_pkg::OP_READ,   8'd1,   32'h0);
        offer_request(psl_pkg::OP_REMOVE, 8'd1,   32'h0);
        offer_request(OP_UNUSED,          8'd0,   32'h0);
        offer_request(psl_pkg::OP_INSERT, 8'd0,   32'h0000_0000);
        offer_request(psl_pkg::OP_INSERT, 8'd1,   32'hFFFF_FFFF);
        offer_request(psl_pkg::OP_INSERT, 8'hFF,  32'hA5A5_5A5A);
        offer_request(psl_pkg::OP_INSERT, 8'd2,   32'h1234_5678);
        offer_request(psl_pkg::OP_INSERT, 8'd5,   32'h8000_0000);
        offer_request(psl_pkg::OP_READ,   8'd0,   32'h0);
        offer_request(psl_pkg::OP_READ,   8'd6,   32'h0);
        for (int p = 1; p <= 5; p++)
            offer_request(psl_pkg::OP_READ, 8'(p), 32'hFFFF_FFFF);
        offer_request(psl_pkg::OP_REMOVE, 8'hFF,  32'h0);
        offer_request(psl_pkg::OP_REMOVE, 8'd0,   32'h0);
        offer_request(psl_pkg::OP_REMOVE, 8'd3,   32'h0);
        offer_request(psl_pkg::OP_REMOVE, 8'd4,   32'h0);
        offer_request(psl_pkg::OP_REMOVE, 8'd1,   32'h0);
        offer_request(OP_UNUSED,          8'hFF,  32'hFFFF_FFFF);
        offer_request(psl_pkg::OP_READ,   8'd2,   32'h0);
        offer_request(psl_pkg::OP_REMOVE, 8'd1,   32'h0);
        offer_request(psl_pkg::OP_REMOVE, 8'd1,   32'h0);
        offer_request(psl_pkg::OP_READ,   8'd1,   32'h0);

        // Random: no idling, with one long receiver hold-off part way in
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
            if (n == 60)
                hold_req <= 1'b1;
            offer_random();
        end

        // Random: sender idles often
        send_idle_pct  <= 59;
        recv_stall_pct <= 0;
        for (int n = 0; n < ITEMS_PER_SET; n++)
            offer_random();

        // Random: receiver stalls often
        send_idle_pct  <= 0;
        recv_stall_pct <= 59;
        for (int n = 0; n < ITEMS_PER_SET; n++)
            offer_random();

        // Random: both sides idle now and then
        send_idle_pct  <= 23;
        recv_stall_pct <= 23;
        for (int n = 0; n < ITEMS_PER_SET; n++)
            offer_random();

        // Drain outstanding results, then watch for strays
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0)
            $display("[positional_shift_list] OK");
        else
            $display("[positional_shift_list] ERROR");
        $finish;
    end

    // Stop a hung run
    initial begin
        #1000000;
        $display("[positional_shift_list] ERROR");
        $finish;
    end

endmodule
